[rtl/array_bst_find_insert_top_defines.svh]
// Assertion macros for the array binary search tree checker.
`ifndef ARRAY_BST_FIND_INSERT_TOP_DEFINES_SVH
`define ARRAY_BST_FIND_INSERT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ABFI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abfi assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ABFI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abfi assertion failed");

`endif

[rtl/abfi_pkg.sv]
// Shared types, constants and microcode table of the array binary search tree.
package abfi_pkg;

    localparam int KEY_W  = 31;
    localparam int SLOT_W = 8;
    localparam int STEP_W = 3;
    localparam int DISP_W = 2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_PRESENT   = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] search_key;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
    } res_t;

    typedef enum logic [STEP_W-1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_HIT,
        S_MISS,
        S_OFF
    } step_e;

    // The walk step dispatches to S_WALK plus this code.
    typedef enum logic [DISP_W-1:0] {
        DSP_WALK,
        DSP_HIT,
        DSP_MISS,
        DSP_OFF
    } disp_e;

    typedef enum logic [2:0] {
        ACT_CLEAR,
        ACT_LOAD,
        ACT_WALK,
        ACT_HIT,
        ACT_MISS,
        ACT_OFF
    } act_e;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START,
        COND_CLR_LAST,
        COND_DISPATCH
    } cond_e;

    typedef struct packed {
        logic  busy;
        act_e  act;
        cond_e cond;
        step_e t_true;
        step_e t_false;
    } uop_t;

    typedef struct packed {
        logic busy;
        act_e act;
    } ctl_t;

    typedef struct packed {
        logic  clr_last;
        disp_e code;
    } flags_t;

    function automatic uop_t rom(input step_e step);
        uop_t u;
        case (step)
            S_CLEAR: u = '{1'b1, ACT_CLEAR, COND_CLR_LAST, S_IDLE, S_CLEAR};
            S_IDLE:  u = '{1'b0, ACT_LOAD,  COND_START,    S_WALK, S_IDLE};
            S_WALK:  u = '{1'b1, ACT_WALK,  COND_DISPATCH, S_WALK, S_IDLE};
            S_HIT:   u = '{1'b1, ACT_HIT,   COND_ALWAYS,   S_IDLE, S_IDLE};
            S_MISS:  u = '{1'b1, ACT_MISS,  COND_ALWAYS,   S_IDLE, S_IDLE};
            S_OFF:   u = '{1'b1, ACT_OFF,   COND_ALWAYS,   S_IDLE, S_IDLE};
            default: u = '{1'b1, ACT_OFF,   COND_ALWAYS,   S_IDLE, S_IDLE};
        endcase
        return u;
    endfunction

endpackage

[rtl/array_bst_find_insert_top.sv]
// Top level of the array binary search tree with find and add requests.
// After reset the block sweeps all 2^TREE_DEPTH-1 slots to empty them, one slot per cycle,
// and holds busy high for those cycles. A request is taken when start is high and busy is
// low. It then visits one tree level per walk step, since the slot memory gives one read
// per cycle, and ends in a hit, miss or off-tree step that sets the result; busy stays high
// through the walk and that last step, so no new request is taken until the last one is done.
// The result appears with done for one cycle right after busy drops and cannot be held off;
// a new request may be taken in that same cycle.
module array_bst_find_insert_top #(
    parameter int TREE_DEPTH = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  abfi_pkg::req_t request,
    output logic           done,
    output abfi_pkg::res_t result
);

    abfi_pkg::ctl_t             ctl;
    abfi_pkg::flags_t           flags;
    logic                       we;
    logic [TREE_DEPTH-1:0]      waddr;
    logic [TREE_DEPTH-1:0]      raddr;
    logic [abfi_pkg::KEY_W:0]   wdata;
    logic [abfi_pkg::KEY_W:0]   rd_data;

    abfi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctl   (ctl)
    );

    abfi_dp #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .ctl     (ctl),
        .rd_data (rd_data),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .flags   (flags),
        .done    (done),
        .result  (result)
    );

    abfi_ram #(
        .WIDTH  (abfi_pkg::KEY_W + 1),
        .DEPTH  (2 ** TREE_DEPTH - 1),
        .ADDR_W (TREE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign busy = ctl.busy;

endmodule

[rtl/abfi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module abfi_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 255,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/abfi_seq.sv]
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module abfi_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  abfi_pkg::flags_t flags,
    output abfi_pkg::ctl_t  ctl
);

    abfi_pkg::step_e step_reg;
    abfi_pkg::step_e step_next;
    abfi_pkg::uop_t  uop;
    logic [abfi_pkg::STEP_W-1:0] disp_ofs;

    assign uop      = abfi_pkg::rom(step_reg);
    assign disp_ofs = {{(abfi_pkg::STEP_W - abfi_pkg::DISP_W){1'b0}}, flags.code};
    assign ctl      = '{busy: uop.busy, act: uop.act};

    always_comb
    begin
        case (uop.cond)
            abfi_pkg::COND_ALWAYS:   step_next = uop.t_true;
            abfi_pkg::COND_START:    step_next = start ? uop.t_true : uop.t_false;
            abfi_pkg::COND_CLR_LAST: step_next = flags.clr_last ? uop.t_true : uop.t_false;
            abfi_pkg::COND_DISPATCH: step_next = abfi_pkg::step_e'(uop.t_true + disp_ofs);
            default:                 step_next = uop.t_false;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= abfi_pkg::S_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[rtl/abfi_dp.sv]
// Datapath: slot index and level registers, key compare, child address and result.
module abfi_dp #(
    parameter int TREE_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  abfi_pkg::req_t        request,
    input  abfi_pkg::ctl_t        ctl,
    input  logic [abfi_pkg::KEY_W:0] rd_data,
    output logic                  we,
    output logic [TREE_DEPTH-1:0] waddr,
    output logic [abfi_pkg::KEY_W:0] wdata,
    output logic [TREE_DEPTH-1:0] raddr,
    output abfi_pkg::flags_t      flags,
    output logic                  done,
    output abfi_pkg::res_t        result
);

    localparam int IDX_W      = TREE_DEPTH;
    localparam int SLOT_COUNT = 2 ** TREE_DEPTH - 1;
    localparam int LVL_W      = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;

    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [LVL_W-1:0]          level_reg;
    logic [LVL_W-1:0]          level_next;
    logic                      done_reg;
    logic                      done_next;
    logic                      op_reg;
    logic                      op_next;
    logic [abfi_pkg::KEY_W-1:0] key_reg;
    logic [abfi_pkg::KEY_W-1:0] key_next;
    abfi_pkg::res_t            result_reg;
    abfi_pkg::res_t            result_next;

    logic                      slot_valid;
    logic [abfi_pkg::KEY_W-1:0] slot_key;
    logic                      go_left;
    logic [IDX_W:0]            child_wide;
    logic [IDX_W-1:0]          child;

    assign slot_valid = rd_data[abfi_pkg::KEY_W];
    assign slot_key   = rd_data[abfi_pkg::KEY_W-1:0];
    assign go_left    = key_reg < slot_key;
    assign child_wide = {idx_reg, 1'b0} + (IDX_W + 1)'(go_left ? 1 : 2);
    assign child      = child_wide[IDX_W-1:0];

    always_comb
    begin
        flags.clr_last = (idx_reg == IDX_W'(SLOT_COUNT - 1));
        if (!slot_valid)
        begin
            flags.code = abfi_pkg::DSP_MISS;
        end
        else if (key_reg == slot_key)
        begin
            flags.code = abfi_pkg::DSP_HIT;
        end
        else if (level_reg == LVL_W'(TREE_DEPTH - 1))
        begin
            flags.code = abfi_pkg::DSP_OFF;
        end
        else
        begin
            flags.code = abfi_pkg::DSP_WALK;
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        level_next  = level_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = '0;
        raddr       = '0;
        case (ctl.act)
            abfi_pkg::ACT_CLEAR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
            end
            abfi_pkg::ACT_LOAD:
            begin
                if (start)
                begin
                    op_next    = request.opcode;
                    key_next   = request.search_key;
                    idx_next   = '0;
                    level_next = '0;
                end
            end
            abfi_pkg::ACT_WALK:
            begin
                raddr = child;
                if (flags.code == abfi_pkg::DSP_WALK)
                begin
                    idx_next   = child;
                    level_next = level_reg + LVL_W'(1);
                end
            end
            abfi_pkg::ACT_HIT:
            begin
                done_next = 1'b1;
                if (op_reg)
                begin
                    result_next = '{status: abfi_pkg::ST_PRESENT, slot_index: '0};
                end
                else
                begin
                    result_next = '{status: abfi_pkg::ST_OK,
                                    slot_index: abfi_pkg::SLOT_W'(idx_reg)};
                end
            end
            abfi_pkg::ACT_MISS:
            begin
                done_next = 1'b1;
                if (op_reg)
                begin
                    we          = 1'b1;
                    wdata       = {1'b1, key_reg};
                    result_next = '{status: abfi_pkg::ST_OK,
                                    slot_index: abfi_pkg::SLOT_W'(idx_reg)};
                end
                else
                begin
                    result_next = '{status: abfi_pkg::ST_NOT_FOUND, slot_index: '0};
                end
            end
            abfi_pkg::ACT_OFF:
            begin
                done_next   = 1'b1;
                result_next = '{status: op_reg ? abfi_pkg::ST_FULL : abfi_pkg::ST_NOT_FOUND,
                                slot_index: '0};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            level_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            level_reg <= level_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/abfi_checker.sv]
// Port-level checker for the array binary search tree, bound to the top level.
`include "array_bst_find_insert_top_defines.svh"

module abfi_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input abfi_pkg::res_t result
);

    logic accepted;
    logic no_slot;

    assign accepted = start && !busy;
    assign no_slot  = (result.status == abfi_pkg::ST_NOT_FOUND)
                   || (result.status == abfi_pkg::ST_PRESENT)
                   || (result.status == abfi_pkg::ST_FULL);

    `ABFI_ASSERT_NEXT(a_accept_busy, accepted, busy)
    `ABFI_ASSERT_NEXT(a_accept_no_done, accepted, !done)
    `ABFI_ASSERT_NOW(a_done_idle, done, !busy)
    `ABFI_ASSERT_NOW(a_slot_zero, done && no_slot, result.slot_index == '0)

endmodule

bind array_bst_find_insert_top abfi_checker u_abfi_checker (.*);

[dv/abfi_tree_checker.sv]
// Request opcodes for the bench, plus the checker that predicts and compares tree results.
package abfi_tb_pkg;

    localparam logic OP_FIND = 1'b0;
    localparam logic OP_ADD  = 1'b1;

endpackage

module abfi_tree_checker #(
    parameter int TREE_DEPTH = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  abfi_pkg::req_t request,
    input  logic           done,
    input  abfi_pkg::res_t result,
    output int             fail_count,
    output int             outstanding,
    output int             result_count,
    output int             miss_count,
    output int             present_count,
    output int             full_count
);
    import abfi_pkg::*;
    import abfi_tb_pkg::*;

    localparam int SLOTS = (1 << TREE_DEPTH) - 1;

    logic [KEY_W-1:0] tree_key  [SLOTS];
    logic             tree_used [SLOTS];
    res_t             pending_results [$];

    // Walks the key's path in the shadow tree, inserting on an add where there is room.
    task automatic walk_tree(input req_t req, output res_t res);
        int unsigned pos;
        logic        hit;
        logic        stop;
        pos  = 0;
        hit  = 1'b0;
        stop = 1'b0;
        while (pos < SLOTS && !stop) begin
            if (!tree_used[pos]) begin
                stop = 1'b1;
            end
            else if (req.search_key == tree_key[pos]) begin
                hit  = 1'b1;
                stop = 1'b1;
            end
            else if (req.search_key < tree_key[pos]) begin
                pos = 2 * pos + 1;
            end
            else begin
                pos = 2 * pos + 2;
            end
        end
        res.slot_index = '0;
        if (req.opcode == OP_FIND) begin
            if (hit) begin
                res.status     = ST_OK;
                res.slot_index = pos[SLOT_W-1:0];
            end
            else begin
                res.status = ST_NOT_FOUND;
            end
        end
        else if (hit) begin
            res.status = ST_PRESENT;
        end
        else if (pos >= SLOTS) begin
            res.status = ST_FULL;
        end
        else begin
            tree_key[pos]  = req.search_key;
            tree_used[pos] = 1'b1;
            res.status     = ST_OK;
            res.slot_index = pos[SLOT_W-1:0];
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                tree_used[i] = 1'b0;
            end
            pending_results.delete();
            fail_count    = 0;
            result_count  = 0;
            miss_count    = 0;
            present_count = 0;
            full_count    = 0;
            outstanding  <= 0;
        end
        else begin
            if (done) begin
                result_count++;
                case (result.status)
                    ST_NOT_FOUND: miss_count++;
                    ST_PRESENT:   present_count++;
                    ST_FULL:      full_count++;
                    default:      ;
                endcase
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                             $time, result.status, result.slot_index);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, result.status);
                        fail_count++;
                    end
                    if (result.slot_index !== want.slot_index) begin
                        $display("%0t: slot_index mismatch, expected %0d, got %0d",
                                 $time, want.slot_index, result.slot_index);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                walk_tree(request, want);
                pending_results.push_back(want);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

[dv/tb_array_bst_find_insert_top.sv]
// Testbench top for the array binary search tree: clock, reset, request stimulus and verdict.
module tb_array_bst_find_insert_top;
    import abfi_pkg::*;
    import abfi_tb_pkg::*;

    localparam int TREE_DEPTH   = 8;
    localparam int ITEMS        = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = TREE_DEPTH + 8;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    res_t result;

    int fail_count;
    int outstanding;
    int result_count;
    int miss_count;
    int present_count;
    int full_count;

    int unsigned      cycles = 0;
    int               sent_count = 0;
    int               add_count = 0;
    logic [KEY_W-1:0] known_keys [$];

    array_bst_find_insert_top #(
        .TREE_DEPTH(TREE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    abfi_tree_checker #(
        .TREE_DEPTH(TREE_DEPTH)
    ) tree_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .result_count(result_count),
        .miss_count(miss_count),
        .present_count(present_count),
        .full_count(full_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic issue(input logic op, input logic [KEY_W-1:0] key);
        start   <= 1'b1;
        request <= '{opcode: op, search_key: key};
        @(posedge clk);
        while (busy) @(posedge clk);
        sent_count++;
        if (op == OP_ADD) begin
            add_count++;
            known_keys.push_back(key);
        end
    endtask

    task automatic rest(input int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Mostly random keys; some land next to stored keys so that paths run deep.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] base;
        if (known_keys.size() == 0 || $urandom_range(0, 4) != 0) begin
            return KEY_W'($urandom);
        end
        base = known_keys[$urandom_range(0, known_keys.size() - 1)];
        if ($urandom_range(0, 1) != 0) begin
            return base + KEY_W'($urandom_range(1, 3));
        end
        return base - KEY_W'($urandom_range(1, 3));
    endfunction

    function automatic logic [KEY_W-1:0] old_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    initial begin
        int pick;
        int idle_pct;
        rst_n   = 1'b0;
        start   <= 1'b0;
        request <= '0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        issue(OP_FIND, 31'h0);
        issue(OP_ADD, 31'h40000000);
        for (int k = 0; k < 7; k++) begin
            issue(OP_ADD, KEY_W'(31'h7FFFFFF8 + k));
        end
        issue(OP_ADD, 31'h7FFFFFFF);
        issue(OP_FIND, 31'h7FFFFFFF);
        issue(OP_FIND, 31'h7FFFFFFE);
        issue(OP_ADD, 31'h7FFFFFFE);
        issue(OP_ADD, 31'h0);
        issue(OP_FIND, 31'h0);
        issue(OP_FIND, 31'h7FFFFFF0);
        issue(OP_ADD, 31'h40000000);
        issue(OP_FIND, 31'h40000000);

        for (int n = 0; n < ITEMS; n++) begin
            if (n % 60 == 0) begin
                pick = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 50;
            end
            if (n >= ITEMS - 100) begin
                idle_pct = 0;
            end
            if (n == ITEMS / 2) begin
                start <= 1'b0;
                @(posedge clk);
                while (outstanding != 0) @(posedge clk);
            end
            rest(idle_pct);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                issue(OP_ADD, fresh_key());
            end
            else if (pick < 60) begin
                issue(OP_ADD, old_key());
            end
            else if (pick < 90) begin
                issue(OP_FIND, old_key());
            end
            else begin
                issue(OP_FIND, fresh_key());
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d adds), checked %0d results.",
                 sent_count, add_count, result_count);
        $display("Outcomes seen: %0d not found, %0d already present, %0d no free slot.",
                 miss_count, present_count, full_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end
        else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[array_bst_find_insert_top.f]
+incdir+rtl
rtl/abfi_pkg.sv
rtl/abfi_ram.sv
rtl/abfi_seq.sv
rtl/abfi_dp.sv
rtl/array_bst_find_insert_top.sv
rtl/abfi_checker.sv
dv/abfi_tree_checker.sv
dv/tb_array_bst_find_insert_top.sv
